>>> design/tcpm_pkg.sv
// Shared types and constants for the three-class priority mailbox.
// No dependencies; imported by the controller, the datapath and the top level.
package tcpm_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int HANDLE_BITS = 16;
  localparam int CLASS_COUNT = 3;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NULL    = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CLS_INIT = 2'd0,
    CLS_SYS  = 2'd1,
    CLS_REG  = 2'd2,
    CLS_NONE = 2'd3
  } class_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } dp_cmd_t;

endpackage

>>> design/tcpm_ctrl.sv
// Sequencer for the mailbox: capture a word, execute it, load the result.
// Depends on tcpm_pkg for the datapath command struct.
module tcpm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tcpm_pkg::dp_cmd_t cmd
);
  import tcpm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  state_t state;
  logic   load_ok;

  assign in_ready    = (state == S_IDLE);
  // result slot is free, or is being emptied this cycle
  assign load_ok     = (state == S_LOAD) && (!out_valid || out_ready);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = (state == S_EXEC);
  assign cmd.load    = load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: state <= S_LOAD;
        S_LOAD: begin
          if (load_ok) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (load_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/tcpm_dpath.sv
// Datapath of the mailbox: three queue stores, pointers, fill counts, result register.
// Depends on tcpm_pkg; driven by commands from tcpm_ctrl.
module tcpm_dpath (
  input  logic              clk,
  input  logic              rst,
  input  tcpm_pkg::dp_cmd_t cmd,
  input  logic              action,
  input  logic [1:0]        msg_class,
  input  logic [15:0]       msg_handle,
  output logic [1:0]        status,
  output logic [15:0]       read_handle,
  output logic [1:0]        served_class
);
  import tcpm_pkg::*;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // captured word
  logic                   act_q;
  class_t                 cls_q;
  logic [HANDLE_BITS-1:0] hnd_q;

  logic [PTR_W-1:0]       head [CLASS_COUNT];
  logic [PTR_W-1:0]       tail [CLASS_COUNT];
  logic [CNT_W-1:0]       count [CLASS_COUNT];
  logic [HANDLE_BITS-1:0] rdata [CLASS_COUNT];

  logic [CLASS_COUNT-1:0] empty;
  logic [CLASS_COUNT-1:0] full;
  logic [CLASS_COUNT-1:0] write_en;
  logic [CLASS_COUNT-1:0] pop_en;
  logic                   full_sel;
  status_t                ins_status;
  class_t                 pop_cls;

  status_t                res_status;
  class_t                 res_served;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q <= action;
      cls_q <= class_t'(msg_class);
      hnd_q <= msg_handle[HANDLE_BITS-1:0];
    end
  end

  assign full_sel = (cls_q == CLS_NONE) ? 1'b0 : full[cls_q];

  always_comb begin
    priority if (hnd_q == '0)       ins_status = ST_NULL;
    else if (cls_q == CLS_NONE)     ins_status = ST_UNKNOWN;
    else if (full_sel)              ins_status = ST_FULL;
    else                            ins_status = ST_OK;
  end

  // strict priority: init, then system, then regular
  always_comb begin
    priority if (!empty[CLS_INIT]) pop_cls = CLS_INIT;
    else if (!empty[CLS_SYS])      pop_cls = CLS_SYS;
    else if (!empty[CLS_REG])      pop_cls = CLS_REG;
    else                           pop_cls = CLS_NONE;
  end

  for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_queue
    logic [HANDLE_BITS-1:0] mem [QUEUE_DEPTH];

    assign empty[g]    = (count[g] == '0);
    assign full[g]     = (count[g] == CNT_W'(QUEUE_DEPTH));
    assign write_en[g] = cmd.exec && (act_q == ACT_INSERT) && (ins_status == ST_OK)
                         && (cls_q == class_t'(g));
    assign pop_en[g]   = cmd.exec && (act_q == ACT_READ) && (pop_cls == class_t'(g));

    always_ff @(posedge clk) begin
      if (write_en[g]) mem[tail[g]] <= hnd_q;
      if (cmd.exec)    rdata[g] <= mem[head[g]];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        head[g]  <= '0;
        tail[g]  <= '0;
        count[g] <= '0;
      end else begin
        if (write_en[g]) begin
          tail[g]  <= next_slot(tail[g]);
          count[g] <= count[g] + 1'b1;
        end else if (pop_en[g]) begin
          head[g]  <= next_slot(head[g]);
          count[g] <= count[g] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= (act_q == ACT_INSERT) ? ins_status : ST_OK;
      res_served <= (act_q == ACT_INSERT) ? CLS_NONE : pop_cls;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status       <= res_status;
      served_class <= res_served;
      read_handle  <= (res_served == CLS_NONE) ? '0 : 16'(rdata[res_served]);
    end
  end

endmodule

>>> design/three_class_priority_mailbox.sv
// Three-class strict-priority mailbox (init > system > regular), 16-deep FIFOs.
// An accepted word is executed, then loaded once the result slot is free.
// No new word is accepted until the last one is loaded; this is set by the
// controller's capture/execute/load sequence and the registered store read ports.
// Reset (synchronous, active high) empties all queues and drops any pending result;
// queue store contents are not cleared and need no clearing pass.
module three_class_priority_mailbox (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [1:0]  msg_class,
  input  logic [15:0] msg_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] read_handle,
  output logic [1:0]  served_class
);
  import tcpm_pkg::*;

  // one command per phase of a word: capture it, execute it, load its result
  dp_cmd_t cmd;

  // The controller accepts a new word only in idle; the result register in
  // the datapath holds the previous result until it is taken, so a word can
  // be accepted while an earlier result still waits downstream.
  tcpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Inserts write the tail of their class's store; reads pop the head of the
  // highest-priority non-empty queue, with the head entry fetched in execute.
  tcpm_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .action       (action),
    .msg_class    (msg_class),
    .msg_handle   (msg_handle),
    .status       (status),
    .read_handle  (read_handle),
    .served_class (served_class)
  );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the three-class priority mailbox: drives insert and read words,
// predicts each result with its own queue model and checks every result word.
// Depends on tcpm_pkg and three_class_priority_mailbox from the design folder.
module tb;
  import tcpm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int SETTLE_CYCLES  = 12;    // settle time after the final drain, in cycles
  localparam int HOLD_OFF_LEN   = 300;   // long receiver stall for the backpressure test
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    status_t     st;
    logic [15:0] handle;
    class_t      served;
  } mailbox_result_t;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_CADENCE} rx_mode_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        action     = ACT_INSERT;
  logic [1:0]  msg_class  = 2'b00;
  logic [15:0] msg_handle = 16'h0000;
  logic        out_ready  = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  status;
  logic [15:0] read_handle;
  logic [1:0]  served_class;

  three_class_priority_mailbox u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .msg_class    (msg_class),
    .msg_handle   (msg_handle),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .read_handle  (read_handle),
    .served_class (served_class)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the three queues: circular stores with head, tail and fill per class.
  logic [15:0]     queue_store [CLASS_COUNT][QUEUE_DEPTH];
  int              queue_head  [CLASS_COUNT];
  int              queue_tail  [CLASS_COUNT];
  int              queue_fill  [CLASS_COUNT];
  mailbox_result_t pending_results[$];

  int  words_sent    = 0;
  int  results_seen  = 0;
  int  fault_count   = 0;
  int  status_seen [4];
  int  served_seen [4];
  bit  gaps_on       = 1'b0;
  int  burst_left    = 0;
  int  hold_off_req  = 0;
  int  hold_left     = 0;
  int  rx_phase      = 0;
  int  rx_tick       = 0;
  rx_mode_t rx_mode  = RX_ALWAYS;
  int  idle_cycles   = 0;

  initial begin
    for (int c = 0; c < CLASS_COUNT; c++) begin
      queue_head[c] = 0;
      queue_tail[c] = 0;
      queue_fill[c] = 0;
    end
    for (int s = 0; s < 4; s++) begin
      status_seen[s] = 0;
      served_seen[s] = 0;
    end
  end

  // Work out the result of one accepted word and advance the queue mirror.
  // Fault order: null handle, then unknown class, then full queue.
  function automatic mailbox_result_t predict_mailbox(input logic act, input logic [1:0] cls,
                                                      input logic [15:0] hnd);
    mailbox_result_t r;
    r.st     = ST_OK;
    r.handle = '0;
    r.served = CLS_NONE;
    if (act == ACT_INSERT) begin
      if (hnd == '0) begin
        r.st = ST_NULL;
      end else if (cls >= CLASS_COUNT) begin
        r.st = ST_UNKNOWN;
      end else if (queue_fill[cls] >= QUEUE_DEPTH) begin
        r.st = ST_FULL;
      end else begin
        queue_store[cls][queue_tail[cls]] = hnd;
        queue_tail[cls] = (queue_tail[cls] + 1) % QUEUE_DEPTH;
        queue_fill[cls]++;
      end
    end else begin
      // Pop from the highest-priority queue that holds anything; class fields are ignored.
      for (int c = 0; c < CLASS_COUNT; c++) begin
        if (r.served == CLS_NONE && queue_fill[c] != 0) begin
          r.handle      = queue_store[c][queue_head[c]];
          queue_head[c] = (queue_head[c] + 1) % QUEUE_DEPTH;
          queue_fill[c]--;
          r.served      = class_t'(c);
        end
      end
    end
    return r;
  endfunction

  // Offer one word, hold it until accepted, then record its expected result.
  // In bursty mode, drop valid for a random gap when the current burst runs out.
  task automatic send_word(input logic act, input logic [1:0] cls, input logic [15:0] hnd);
    mailbox_result_t predicted;
    int gap;
    in_valid   <= 1'b1;
    action     <= act;
    msg_class  <= cls;
    msg_handle <= hnd;
    do @(posedge clk); while (!in_ready);
    predicted = predict_mailbox(act, cls, hnd);
    pending_results.insert(pending_results.size(), predicted);
    words_sent++;
    status_seen[predicted.st]++;
    if (act == ACT_READ) served_seen[predicted.served]++;
    if (gaps_on) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic send_random_word(input int insert_pct);
    logic       act;
    logic [1:0] cls;
    logic [15:0] hnd;
    int roll;
    act  = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_READ;
    cls  = ($urandom_range(0, 99) < 8) ? CLS_NONE : 2'($urandom_range(0, 2));
    roll = $urandom_range(0, 99);
    if (roll < 5)       hnd = 16'h0000;
    else if (roll < 10) hnd = 16'hFFFF;
    else                hnd = 16'($urandom);
    send_word(act, cls, hnd);
  endtask

  // Stop offering and hold until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Result checker: compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    mailbox_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_fault($sformatf("result st=%0d handle=%h class=%0d with nothing expected",
                               status, read_handle, served_class));
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (status !== want.st || read_handle !== want.handle || served_class !== want.served)
          report_fault($sformatf({"result %0d: expected st=%0d handle=%h class=%0d, ",
                                  "got st=%0d handle=%h class=%0d"},
                                 results_seen, want.st, want.handle, want.served,
                                 status, read_handle, served_class));
      end
    end
  end

  // Receiver: pick a new stall pattern at random intervals; a hold-off request
  // overrides the pattern and keeps ready low for the requested count.
  always @(posedge clk) begin
    if (hold_off_req != 0) begin
      hold_left    = hold_off_req;
      hold_off_req = 0;
    end
    if (rx_phase == 0) begin
      rx_mode  = rx_mode_t'($urandom_range(0, 3));
      rx_phase = $urandom_range(16, 96);
    end
    rx_phase--;
    rx_tick++;
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        default:   out_ready <= ((rx_tick % 5) < 3);
      endcase
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles, %0d results still expected",
               idle_cycles, pending_results.size());
      $display("three_class_priority_mailbox verification failed");
      $finish;
    end
  end

  // Read an empty mailbox with the ignored fields at both extremes.
  task automatic test_empty_read();
    send_word(ACT_READ, 2'b00, 16'h0000);
    send_word(ACT_READ, 2'b11, 16'hFFFF);
    wait_drained();
  endtask

  // Reject faulty inserts: null beats unknown class, unknown class alone.
  task automatic test_insert_faults();
    send_word(ACT_INSERT, CLS_INIT, 16'h0000);
    send_word(ACT_INSERT, CLS_NONE, 16'h0000);
    send_word(ACT_INSERT, CLS_NONE, 16'hFFFF);
    send_word(ACT_INSERT, CLS_NONE, 16'h0001);
    send_word(ACT_READ,   CLS_INIT, 16'h1234);
    wait_drained();
  endtask

  // Serve init before system before regular, FIFO order within a class.
  task automatic test_priority_order();
    send_word(ACT_INSERT, CLS_REG,  16'hFFFF);
    send_word(ACT_INSERT, CLS_SYS,  16'h0001);
    send_word(ACT_INSERT, CLS_INIT, 16'h8000);
    send_word(ACT_INSERT, CLS_INIT, 16'h7FFF);
    send_word(ACT_READ,   CLS_REG,  16'h0000);
    send_word(ACT_READ,   CLS_NONE, 16'hFFFF);
    send_word(ACT_READ,   CLS_SYS,  16'h5A5A);
    send_word(ACT_READ,   CLS_INIT, 16'hA5A5);
    send_word(ACT_READ,   CLS_REG,  16'h0001);
    wait_drained();
  endtask

  // Fill each queue past its depth, check null still outranks full, then drain all.
  task automatic test_fill_and_drain();
    gaps_on = 1'b1;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      for (int k = 0; k < QUEUE_DEPTH + 1; k++)
        send_word(ACT_INSERT, 2'(c), 16'($urandom_range(1, 16'hFFFF)));
      send_word(ACT_INSERT, 2'(c), 16'h0000);
      for (int k = 0; k < 4; k++)
        send_word(ACT_INSERT, 2'($urandom_range(0, 2)), 16'($urandom_range(1, 16'hFFFF)));
    end
    while (queue_fill[0] + queue_fill[1] + queue_fill[2] != 0)
      send_word(ACT_READ, 2'($urandom), 16'($urandom));
    send_word(ACT_READ, 2'($urandom), 16'($urandom));
    wait_drained();
  endtask

  // Mixed traffic in chunks whose insert share varies, so queues fill and empty.
  task automatic test_random_traffic();
    int insert_pct;
    for (int chunk = 0; chunk < 8; chunk++) begin
      insert_pct = $urandom_range(30, 80);
      gaps_on    = (chunk % 4 != 3);
      for (int k = 0; k < 40; k++) send_random_word(insert_pct);
    end
    wait_drained();
  endtask

  // Hold off the receiver while offering words back to back until input stalls.
  task automatic test_backpressure();
    gaps_on      = 1'b0;
    hold_off_req = HOLD_OFF_LEN;
    for (int k = 0; k < 48; k++) send_random_word(60);
    gaps_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_read();
    test_insert_faults();
    test_priority_order();
    test_fill_and_drain();
    test_random_traffic();
    test_backpressure();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display({"Run covered %0d words in, %0d results checked; ",
              "ok/null/unknown/full = %0d/%0d/%0d/%0d"},
             words_sent, results_seen, status_seen[ST_OK], status_seen[ST_NULL],
             status_seen[ST_UNKNOWN], status_seen[ST_FULL]);
    $display("Reads served init/system/regular/empty = %0d/%0d/%0d/%0d, %0d mismatches",
             served_seen[CLS_INIT], served_seen[CLS_SYS], served_seen[CLS_REG],
             served_seen[CLS_NONE], fault_count);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("three_class_priority_mailbox verification clean");
    end else begin
      $display("three_class_priority_mailbox verification failed");
    end
    $finish;
  end

endmodule

>>> three_class_priority_mailbox.f
design/tcpm_pkg.sv
design/tcpm_ctrl.sv
design/tcpm_dpath.sv
design/three_class_priority_mailbox.sv
bench/tb.sv
